// ===== hw/rtl/morse_key_decoder_assert.svh =====
// Assertion macros used by the Morse key decoder core (mkd_core).
`ifndef MORSE_KEY_DECODER_ASSERT_SVH
`define MORSE_KEY_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mkd assertion failed");

// Next-cycle implication, checked out of reset.
`define MKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkd assertion failed");

`endif

// ===== hw/rtl/mkd_pkg.sv =====
// Shared types, constants and letter table for the Morse key decoder.
package mkd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MAX_SYMBOLS_DEF = 4;

  localparam int REG_W       = 16;
  localparam int REG_IDX_W   = 3;
  localparam int KIND_W      = 2;
  localparam int LETTER_W    = 7;
  localparam int TABLE_IDX_W = 5;
  localparam int TABLE_SIZE  = 32;
  localparam int CODE_EXT_W  = 8;

  localparam logic [REG_IDX_W-1:0] REG_MIN_PRESS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESS_CAP = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DOT_LIMIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DASH_LIMIT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAP_LIMIT = 3'd4;

  localparam logic [REG_W-1:0] MIN_PRESS_RST  = 16'd100;
  localparam logic [REG_W-1:0] PRESS_CAP_RST  = 16'd3000;
  localparam logic [REG_W-1:0] DOT_LIMIT_RST  = 16'd500;
  localparam logic [REG_W-1:0] DASH_LIMIT_RST = 16'd2000;
  localparam logic [REG_W-1:0] GAP_LIMIT_RST  = 16'd3000;

  localparam logic [KIND_W-1:0] KIND_DOT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DASH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LETTER = 2'd2;

  localparam logic [LETTER_W-1:0] LETTER_A = 7'h41;

  // code word with leading marker -> ASCII capital, zero where no letter
  localparam logic [LETTER_W-1:0] LETTER_TABLE [TABLE_SIZE] = '{
    7'h00, 7'h00, 7'h45, 7'h54, 7'h49, 7'h41, 7'h4E, 7'h4D,
    7'h53, 7'h55, 7'h52, 7'h57, 7'h44, 7'h4B, 7'h47, 7'h4F,
    7'h48, 7'h56, 7'h46, 7'h00, 7'h4C, 7'h00, 7'h50, 7'h4A,
    7'h42, 7'h58, 7'h43, 7'h59, 7'h5A, 7'h51, 7'h00, 7'h00
  };

  typedef struct packed {
    logic [REG_W-1:0] min_press;
    logic [REG_W-1:0] press_cap;
    logic [REG_W-1:0] dot_limit;
    logic [REG_W-1:0] dash_limit;
    logic [REG_W-1:0] gap_limit;
  } mkd_cfg_t;

  typedef struct packed {
    logic                fire;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
    logic                invalid;
  } mkd_res_t;

endpackage

// ===== hw/rtl/morse_key_decoder.sv =====
// Top level of the Morse key decoder: config registers, handshakes, result register.
//
//   port group  dir  beat contents                        handshake
//   in_*        in   in_key_down                          in_valid / in_stall
//   out_*       out  out_kind, out_letter_code,            out_valid / out_stall
//                    out_invalid_letter
//   cfg_*       in   cfg_index, cfg_data                  cfg_valid / cfg_ready
//
// One input beat per clock while in_stall is low; its result, if any, is in the
// output register the next cycle. It is formed combinationally from the press/gap
// counters and code word. in_stall is high only while a held result is stalled.
// cfg_ready is always high. Synchronous active-low reset restores the default
// limits and empties the code buffer.
module morse_key_decoder #(
  parameter int COUNT_WIDTH = mkd_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_key_down,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mkd_pkg::KIND_W-1:0]       out_kind,
  output logic [mkd_pkg::LETTER_W-1:0]     out_letter_code,
  output logic                             out_invalid_letter,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mkd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [mkd_pkg::REG_W-1:0]        cfg_data
);

  mkd_pkg::mkd_cfg_t cfg_r, cfg_nxt;
  mkd_pkg::mkd_res_t res;
  logic              step;
  logic              out_valid_r, out_valid_nxt;
  logic [mkd_pkg::KIND_W-1:0]   kind_r;
  logic [mkd_pkg::LETTER_W-1:0] letter_r;
  logic                         invalid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign step      = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mkd_pkg::REG_MIN_PRESS:  cfg_nxt.min_press  = cfg_data;
        mkd_pkg::REG_PRESS_CAP:  cfg_nxt.press_cap  = cfg_data;
        mkd_pkg::REG_DOT_LIMIT:  cfg_nxt.dot_limit  = cfg_data;
        mkd_pkg::REG_DASH_LIMIT: cfg_nxt.dash_limit = cfg_data;
        mkd_pkg::REG_GAP_LIMIT:  cfg_nxt.gap_limit  = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press  <= mkd_pkg::MIN_PRESS_RST;
      cfg_r.press_cap  <= mkd_pkg::PRESS_CAP_RST;
      cfg_r.dot_limit  <= mkd_pkg::DOT_LIMIT_RST;
      cfg_r.dash_limit <= mkd_pkg::DASH_LIMIT_RST;
      cfg_r.gap_limit  <= mkd_pkg::GAP_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mkd_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .key_down (in_key_down),
    .cfg      (cfg_r),
    .res      (res)
  );

  always_comb begin
    if (step && res.fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.fire) begin
      kind_r    <= res.kind;
      letter_r  <= res.letter;
      invalid_r <= res.invalid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_letter_code    = letter_r;
  assign out_invalid_letter = invalid_r;

endmodule

// ===== hw/rtl/mkd_core.sv =====
// Press and gap timing, symbol buffer and letter lookup of the Morse key decoder.
`include "morse_key_decoder_assert.svh"

module mkd_core #(
  parameter int COUNT_WIDTH = mkd_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_SYMBOLS = mkd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               key_down,
  input  mkd_pkg::mkd_cfg_t  cfg,
  output mkd_pkg::mkd_res_t  res
);

  localparam int CMP_W  = (COUNT_WIDTH > mkd_pkg::REG_W) ? COUNT_WIDTH : mkd_pkg::REG_W;
  localparam int CODE_W = MAX_SYMBOLS + 1;
  localparam int SCNT_W = $clog2(MAX_SYMBOLS + 1);

  logic [COUNT_WIDTH-1:0] press_r, press_nxt;
  logic [COUNT_WIDTH-1:0] gap_r, gap_nxt;
  logic                   gap_run_r, gap_run_nxt;
  logic [CODE_W-1:0]      code_r, code_nxt;
  logic [SCNT_W-1:0]      scnt_r, scnt_nxt;
  logic                   too_long_r, too_long_nxt;
  logic                   prev_r, prev_nxt;

  logic [COUNT_WIDTH-1:0] press_inc, gap_inc;
  logic [CMP_W-1:0]       press_x;
  logic                   valid_press, is_dot, is_dash, gap_done;
  logic [mkd_pkg::CODE_EXT_W-1:0] code_ext;
  logic [mkd_pkg::LETTER_W-1:0]   letter;

  assign press_inc = (&press_r) ? press_r : press_r + 1'b1;
  assign gap_inc   = (&gap_r) ? gap_r : gap_r + 1'b1;
  assign press_x   = CMP_W'(press_r);

  assign valid_press = prev_r && (press_x > CMP_W'(cfg.min_press))
                              && (press_x < CMP_W'(cfg.press_cap));
  assign is_dot   = press_x < CMP_W'(cfg.dot_limit);
  assign is_dash  = !is_dot && (press_x <= CMP_W'(cfg.dash_limit));
  assign gap_done = CMP_W'(gap_inc) >= CMP_W'(cfg.gap_limit);

  assign code_ext = mkd_pkg::CODE_EXT_W'(code_r);
  assign letter = (!too_long_r &&
                   code_ext[mkd_pkg::CODE_EXT_W-1:mkd_pkg::TABLE_IDX_W] == '0) ?
                  mkd_pkg::LETTER_TABLE[code_ext[mkd_pkg::TABLE_IDX_W-1:0]] : '0;

  always_comb begin
    press_nxt    = press_r;
    gap_nxt      = gap_r;
    gap_run_nxt  = gap_run_r;
    code_nxt     = code_r;
    scnt_nxt     = scnt_r;
    too_long_nxt = too_long_r;
    prev_nxt     = prev_r;
    res          = '0;
    if (step) begin
      if (key_down) begin
        press_nxt = press_inc;
        prev_nxt  = 1'b1;
      end else begin
        if (prev_r) begin
          press_nxt = '0;
          prev_nxt  = 1'b0;
        end
        if (valid_press) begin
          gap_run_nxt = 1'b1;
          gap_nxt     = '0;
          if (is_dot || is_dash) begin
            if (scnt_r < SCNT_W'(MAX_SYMBOLS)) begin
              code_nxt = {code_r[CODE_W-2:0], !is_dot};
              scnt_nxt = scnt_r + 1'b1;
            end else begin
              too_long_nxt = 1'b1;
            end
            res.fire = 1'b1;
            res.kind = is_dot ? mkd_pkg::KIND_DOT : mkd_pkg::KIND_DASH;
          end
        end else if (gap_run_r) begin
          if (gap_done) begin
            gap_run_nxt  = 1'b0;
            gap_nxt      = '0;
            code_nxt     = CODE_W'(1);
            scnt_nxt     = '0;
            too_long_nxt = 1'b0;
            if (scnt_r != '0 || too_long_r) begin
              res.fire    = 1'b1;
              res.kind    = mkd_pkg::KIND_LETTER;
              res.letter  = letter;
              res.invalid = (letter == '0);
            end
          end else begin
            gap_nxt = gap_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r    <= '0;
      gap_r      <= '0;
      gap_run_r  <= 1'b0;
      code_r     <= CODE_W'(1);
      scnt_r     <= '0;
      too_long_r <= 1'b0;
      prev_r     <= 1'b0;
    end else begin
      press_r    <= press_nxt;
      gap_r      <= gap_nxt;
      gap_run_r  <= gap_run_nxt;
      code_r     <= code_nxt;
      scnt_r     <= scnt_nxt;
      too_long_r <= too_long_nxt;
      prev_r     <= prev_nxt;
    end
  end

  `MKD_ASSERT_NOW(a_marker_pos, 1'b1, (code_r >> scnt_r) == CODE_W'(1))
  `MKD_ASSERT_NOW(a_overflow_full, too_long_r, scnt_r == SCNT_W'(MAX_SYMBOLS))
  `MKD_ASSERT_NOW(a_no_result_on_press, step && key_down, !res.fire)
  `MKD_ASSERT_NEXT(a_letter_clears, step && res.fire && res.kind == mkd_pkg::KIND_LETTER,
                   scnt_r == '0 && !too_long_r && !gap_run_r)
  `MKD_ASSERT_NOW(a_letter_ascii,
                  res.fire && res.kind == mkd_pkg::KIND_LETTER && !res.invalid,
                  res.letter >= mkd_pkg::LETTER_A)

endmodule

// ===== sim/testbench.sv =====
// Testbench for morse_key_decoder: table of keyed beats, then random keying checked by a decode model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                       key;
    logic [7:0]                 beats;
    logic                       typed;
    logic [mkd_pkg::KIND_W-1:0] kind;
    logic [7:0]                 letter;
    logic                       invalid;
  } key_row_t;

  typedef struct packed {
    logic [mkd_pkg::REG_W-1:0] min_press, press_cap, dot_limit, dash_limit, gap_limit;
    int unsigned               idle_pct, stall_pct, beats;
  } phase_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_key_down = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mkd_pkg::KIND_W-1:0]     out_kind;
  logic [mkd_pkg::LETTER_W-1:0]   out_letter_code;
  logic                           out_invalid_letter;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mkd_pkg::REG_IDX_W-1:0]  cfg_index = '0;
  logic [mkd_pkg::REG_W-1:0]      cfg_data = '0;

  // limits as last written
  logic [mkd_pkg::REG_W-1:0] lim_min  = mkd_pkg::MIN_PRESS_RST;
  logic [mkd_pkg::REG_W-1:0] lim_cap  = mkd_pkg::PRESS_CAP_RST;
  logic [mkd_pkg::REG_W-1:0] lim_dot  = mkd_pkg::DOT_LIMIT_RST;
  logic [mkd_pkg::REG_W-1:0] lim_dash = mkd_pkg::DASH_LIMIT_RST;
  logic [mkd_pkg::REG_W-1:0] lim_gap  = mkd_pkg::GAP_LIMIT_RST;

  // decoder state
  logic [mkd_pkg::COUNT_WIDTH_DEF-1:0] press_cnt = '0;
  logic [mkd_pkg::COUNT_WIDTH_DEF-1:0] gap_cnt = '0;
  logic                                gap_on = 1'b0;
  logic                                key_was = 1'b0;
  logic                                overflow = 1'b0;
  logic [4:0]                          code = 5'd1;
  logic [2:0]                          nsym = '0;

  byte alpha [32] = '{
    0, 0, "E", "T", "I", "A", "N", "M",
    "S", "U", "R", "W", "D", "K", "G", "O",
    "H", "V", "F", 0, "L", 0, "P", "J",
    "B", "X", "C", "Y", "Z", "Q", 0, 0
  };

  // dash dash dot dash, then five dots
  key_row_t key_rows [20] = '{
    '{1'b1, 8'd2, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DASH,   8'd0, 1'b0},
    '{1'b1, 8'd2, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DASH,   8'd0, 1'b0},
    '{1'b1, 8'd1, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b1, 8'd2, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DASH,   8'd0, 1'b0},
    '{1'b0, 8'd2, 1'b1, mkd_pkg::KIND_LETTER, "Q",  1'b0},
    '{1'b1, 8'd1, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b1, 8'd1, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b1, 8'd1, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b1, 8'd1, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b1, 8'd1, 1'b0, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd1, 1'b1, mkd_pkg::KIND_DOT,    8'd0, 1'b0},
    '{1'b0, 8'd2, 1'b1, mkd_pkg::KIND_LETTER, 8'd0, 1'b1}
  };

  phase_t phases [6] = '{
    '{16'd2,    16'd14,   16'd6, 16'd11,   16'd8, 0,  0,  480},
    '{16'd2,    16'd14,   16'd6, 16'd11,   16'd8, 46, 0,  300},
    '{16'd1,    16'd12,   16'd8, 16'd4,    16'd5, 0,  46, 300},
    '{16'd0,    16'hFFFF, 16'd3, 16'hFFFF, 16'd0, 27, 27, 300},
    '{16'd1,    16'd9,    16'd4, 16'd8,    16'd3, 27, 27, 300},
    '{16'hFFFF, 16'd0,    16'd0, 16'd0,    16'd1, 46, 0,  100}
  };

  mkd_pkg::mkd_res_t due_marks [$];
  int unsigned       in_idle_pct = 0;
  int unsigned       out_stall_pct = 0;
  int unsigned       beats_sent = 0;
  int unsigned       errors = 0;

  morse_key_decoder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_down       (in_key_down),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_letter_code   (out_letter_code),
    .out_invalid_letter(out_invalid_letter),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin : check_marks
    mkd_pkg::mkd_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_marks.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d letter=%h invalid=%b", $time,
                 out_kind, out_letter_code, out_invalid_letter);
        errors++;
      end else begin
        want = due_marks.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          errors++;
        end
        if (out_letter_code !== want.letter) begin
          $display("%0t: letter_code expected %h actual %h", $time, want.letter,
                   out_letter_code);
          errors++;
        end
        if (out_invalid_letter !== want.invalid) begin
          $display("%0t: invalid_letter expected %b actual %b", $time, want.invalid,
                   out_invalid_letter);
          errors++;
        end
      end
    end
  end

  task automatic shift_symbol(input logic b);
    if (nsym < 3'(mkd_pkg::MAX_SYMBOLS_DEF)) begin
      code = {code[3:0], b};
      nsym++;
    end else begin
      overflow = 1'b1;
    end
  endtask

  task automatic decode_key_sample(input logic k, output mkd_pkg::mkd_res_t r);
    logic [mkd_pkg::COUNT_WIDTH_DEF-1:0] held;
    r = '0;
    if (k) begin
      if (press_cnt != '1) press_cnt++;
      key_was = 1'b1;
      return;
    end
    if (key_was) begin
      held = press_cnt;
      press_cnt = '0;
      key_was = 1'b0;
      if (held > lim_min && held < lim_cap) begin
        gap_on = 1'b1;
        gap_cnt = '0;
        if (held < lim_dot) begin
          shift_symbol(1'b0);
          r.fire = 1'b1;
          r.kind = mkd_pkg::KIND_DOT;
        end else if (held <= lim_dash) begin
          shift_symbol(1'b1);
          r.fire = 1'b1;
          r.kind = mkd_pkg::KIND_DASH;
        end
        return;
      end
    end
    if (gap_on) begin
      if (gap_cnt != '1) gap_cnt++;
      if (gap_cnt >= lim_gap) begin
        gap_on = 1'b0;
        gap_cnt = '0;
        if (nsym != 0 || overflow) begin
          r.fire = 1'b1;
          r.kind = mkd_pkg::KIND_LETTER;
          r.letter = overflow ? 7'd0 : alpha[code][mkd_pkg::LETTER_W-1:0];
          r.invalid = (r.letter == '0);
        end
        code = 5'd1;
        nsym = '0;
        overflow = 1'b0;
      end
    end
  endtask

  task automatic send_key(input logic k, output mkd_pkg::mkd_res_t r);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_down <= k;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    decode_key_sample(k, r);
  endtask

  task automatic send_run(input logic k, input int n);
    mkd_pkg::mkd_res_t got;
    repeat (n) begin
      send_key(k, got);
      if (got.fire) due_marks.push_back(got);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_marks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [mkd_pkg::REG_W-1:0] mn, cp, dt, ds, gp);
    logic [mkd_pkg::REG_IDX_W-1:0] idx [5];
    logic [mkd_pkg::REG_W-1:0]     val [5];
    idx = '{mkd_pkg::REG_MIN_PRESS, mkd_pkg::REG_PRESS_CAP, mkd_pkg::REG_DOT_LIMIT,
            mkd_pkg::REG_DASH_LIMIT, mkd_pkg::REG_GAP_LIMIT};
    val = '{mn, cp, dt, ds, gp};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    lim_min = mn;
    lim_cap = cp;
    lim_dot = dt;
    lim_dash = ds;
    lim_gap = gp;
  endtask

  function automatic int pick(input int lo, input int hi);
    if (hi - lo <= 63) return int'($urandom_range(hi, lo));
    if ($urandom_range(1) == 1 && hi <= 4000) return int'($urandom_range(hi, hi - 63));
    return int'($urandom_range(lo + 63, lo));
  endfunction

  // dots and dashes mostly, now and then too short, too long or valid without a symbol
  function automatic int press_len();
    int mn, cp, dt, ds, lo, hi, sel, t;
    mn = int'(lim_min);
    cp = int'(lim_cap);
    dt = int'(lim_dot);
    ds = int'(lim_dash);
    for (t = 0; t < 8; t++) begin
      sel = int'($urandom_range(9));
      if (sel < 4) begin
        lo = mn + 1;
        hi = ((dt < cp) ? dt : cp) - 1;
      end else if (sel < 8) begin
        lo = (dt > mn + 1) ? dt : mn + 1;
        hi = (ds < cp - 1) ? ds : cp - 1;
      end else if (sel == 8) begin
        lo = 1;
        hi = (mn < 200) ? mn : 200;
      end else if ($urandom_range(1) == 0) begin
        lo = (dt > mn + 1) ? dt : mn + 1;
        if (ds + 1 > lo) lo = ds + 1;
        hi = cp - 1;
      end else begin
        lo = (cp > 1) ? cp : 1;
        hi = lo + 3;
      end
      if (lo <= hi && lo <= 4000) return pick(lo, hi);
    end
    return 1;
  endfunction

  task automatic send_letter();
    int n, k, extra, eff_gap;
    eff_gap = (lim_gap == 0) ? 1 : int'(lim_gap);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(20, 1)) send_run(1'($urandom_range(1)), 1);
      return;
    end
    n = ($urandom_range(7) == 0) ? int'($urandom_range(6, 5)) : int'($urandom_range(4, 1));
    for (k = 0; k < n; k++) begin
      send_run(1'b1, press_len());
      send_run(1'b0, 1);
      if (k < n - 1) begin
        if ($urandom_range(9) == 0) extra = eff_gap + int'($urandom_range(2));
        else extra = (eff_gap >= 2) ? pick(0, eff_gap - 2) : 0;
        send_run(1'b0, extra);
      end
    end
    send_run(1'b0, eff_gap + int'($urandom_range(2)));
  endtask

  initial begin
    mkd_pkg::mkd_res_t got;
    mkd_pkg::mkd_res_t typed;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_limits(16'd0, 16'd4, 16'd2, 16'd2, 16'd2);
    foreach (key_rows[i]) begin
      for (int n = 0; n < key_rows[i].beats; n++) begin
        send_key(key_rows[i].key, got);
        if (key_rows[i].typed && n == key_rows[i].beats - 1) begin
          typed.fire = 1'b1;
          typed.kind = key_rows[i].kind;
          typed.letter = key_rows[i].letter[mkd_pkg::LETTER_W-1:0];
          typed.invalid = key_rows[i].invalid;
          due_marks.push_back(typed);
        end else if (got.fire) begin
          due_marks.push_back(got);
        end
      end
    end
    drain();

    foreach (phases[p]) begin
      set_limits(phases[p].min_press, phases[p].press_cap, phases[p].dot_limit,
                 phases[p].dash_limit, phases[p].gap_limit);
      in_idle_pct = phases[p].idle_pct;
      out_stall_pct <= phases[p].stall_pct;
      beats_sent = 0;
      while (beats_sent < phases[p].beats) send_letter();
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_core.sv
hw/rtl/morse_key_decoder.sv
sim/testbench.sv
